FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CVS_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

FILE: rtl/cvs_pkg.sv
`timescale 1ns / 1ps
package cvs_pkg;

  localparam int CVS_CORDIC_STEPS = 16;
  localparam int CW = 30;
  localparam int DEG_ONE = 65536;
  localparam int CORDIC_GAIN = 10188014;
  localparam int FULL_CD = 36000;
  localparam int HALF_CD = 18000;
  localparam int AVG_LIM = 65536;
  localparam logic [31:0] RECIP_100 = 32'h51EB851F;
  localparam int RECIP_SHIFT = 37;

  localparam logic [13:0] ENTER_RST = 14'd100;
  localparam logic [13:0] EXIT_RST = 14'd80;
  localparam logic [15:0] ALPHA_RST = 16'd6554;

  typedef enum logic [1:0] {
    CFG_ENTER = 2'd0,
    CFG_EXIT  = 2'd1,
    CFG_ALPHA = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic rot_init;
    logic vec_init;
    logic iter;
    logic sc;
    logic smooth;
    logic ang;
    logic result;
  } cvs_cmd_t;

  typedef struct packed {
    logic trusted;
    logic iter_last;
    logic out_busy;
  } cvs_stat_t;

  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/cvs_ctrl.sv
`timescale 1ns / 1ps
module cvs_ctrl
  import cvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cvs_stat_t stat_i,
  output cvs_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CONV     = 10'b0000000010,
    S_ROT_INIT = 10'b0000000100,
    S_ROT      = 10'b0000001000,
    S_SC       = 10'b0000010000,
    S_SMOOTH   = 10'b0000100000,
    S_VEC_INIT = 10'b0001000000,
    S_VEC      = 10'b0010000000,
    S_ANG      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (stat_i.trusted) begin
          cmd_o.conv = 1'b1;
          state_d = S_ROT_INIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ROT_INIT: begin
        cmd_o.rot_init = 1'b1;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.iter = 1'b1;
        if (stat_i.iter_last) state_d = S_SC;
      end
      S_SC: begin
        cmd_o.sc = 1'b1;
        state_d = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d = S_VEC_INIT;
      end
      S_VEC_INIT: begin
        cmd_o.vec_init = 1'b1;
        state_d = S_VEC;
      end
      S_VEC: begin
        cmd_o.iter = 1'b1;
        if (stat_i.iter_last) state_d = S_ANG;
      end
      S_ANG: begin
        cmd_o.ang = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.result = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cvs_datapath.sv
`timescale 1ns / 1ps
module cvs_datapath
  import cvs_pkg::*;
#(
  parameter int CORDIC_STEPS = CVS_CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [13:0]        ground_speed_i,
  input  logic [15:0]        raw_course_i,
  input  logic [15:0]        target_bearing_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [15:0]        damped_course_o,
  output logic               damped_valid_o,
  output logic signed [15:0] track_error_o,
  input  cvs_cmd_t           cmd_i,
  output cvs_stat_t          stat_o
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic signed [CW-1:0] D90  = CW'(90 * DEG_ONE);
  localparam logic signed [CW-1:0] D180 = CW'(180 * DEG_ONE);
  localparam logic signed [CW-1:0] D360 = CW'(360 * DEG_ONE);
  localparam logic signed [CW-1:0] GAIN = CW'(CORDIC_GAIN);
  localparam logic signed [CW-1:0] LIM_HI = CW'(AVG_LIM);
  localparam logic signed [CW-1:0] LIM_LO = -CW'(AVG_LIM);

  logic [13:0] enter_q, exit_q;
  logic [15:0] alpha_q;
  logic        latch_q, latch_d, seeded_q, out_valid_q;
  logic signed [17:0] sin_avg_q, cos_avg_q, s16_q, c16_q;
  logic [15:0] hold_q, course_q, bearing_q;
  logic [63:0] prod_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic [IW-1:0] i_q;
  logic flip_q, vec_q, zero_q;
  logic [15:0] out_course_q;
  logic out_dvalid_q;
  logic signed [15:0] out_err_q;

  // Load stage
  logic [15:0] course_mod, bearing_mod;
  always_comb begin
    course_mod = (raw_course_i >= 16'(FULL_CD)) ? raw_course_i - 16'(FULL_CD) : raw_course_i;
    bearing_mod = (target_bearing_i >= 16'(FULL_CD)) ?
                  target_bearing_i - 16'(FULL_CD) : target_bearing_i;
    latch_d = latch_q;
    if (ground_speed_i >= enter_q) latch_d = 1'b1;
    else if (ground_speed_i < exit_q) latch_d = 1'b0;
  end

  // Rotation set-up
  logic signed [CW-1:0] a0, a1, a2;
  logic flip_d;
  always_comb begin
    a0 = signed'({3'b000, prod_q[63:RECIP_SHIFT]});
    a1 = (a0 > D180) ? a0 - D360 : a0;
    flip_d = 1'b0;
    a2 = a1;
    if (a1 > D90) begin
      a2 = a1 - D180;
      flip_d = 1'b1;
    end else if (a1 < -D90) begin
      a2 = a1 + D180;
      flip_d = 1'b1;
    end
  end

  // Shared CORDIC step
  logic signed [CW-1:0] dx, dy, at, x_n, y_n, z_n;
  logic sigma;
  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = signed'(CW'(atan_lut(5'(i_q))));
    sigma = vec_q ? !(y_q > 0) : (z_q >= 0);
    if (sigma) begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - at;
    end else begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + at;
    end
  end

  // Sine and cosine to Q1.16
  logic signed [CW-1:0] s24, c24, st, ct;
  logic signed [17:0] s16, c16;
  always_comb begin
    s24 = flip_q ? -y_q : y_q;
    c24 = flip_q ? -x_q : x_q;
    st = (s24 + CW'(128)) >>> 8;
    ct = (c24 + CW'(128)) >>> 8;
    s16 = (st > LIM_HI) ? 18'(LIM_HI) : ((st < LIM_LO) ? 18'(LIM_LO) : 18'(st));
    c16 = (ct > LIM_HI) ? 18'(LIM_HI) : ((ct < LIM_LO) ? 18'(LIM_LO) : 18'(ct));
  end

  // Exponential smoothing
  logic signed [16:0] alpha_s;
  logic signed [18:0] ds, dc;
  logic signed [35:0] ps, pc;
  logic signed [19:0] adj_s, adj_c;
  logic signed [20:0] sum_s, sum_c;
  logic signed [17:0] new_s, new_c;
  always_comb begin
    alpha_s = {1'b0, alpha_q};
    ds = 19'(s16_q) - 19'(sin_avg_q);
    dc = 19'(c16_q) - 19'(cos_avg_q);
    ps = alpha_s * ds;
    pc = alpha_s * dc;
    adj_s = 20'((ps + 36'sd32768) >>> 16);
    adj_c = 20'((pc + 36'sd32768) >>> 16);
    sum_s = 21'(sin_avg_q) + 21'(adj_s);
    sum_c = 21'(cos_avg_q) + 21'(adj_c);
    new_s = (sum_s > 21'sd131071) ? 18'sd131071 :
            ((sum_s < -21'sd131072) ? -18'sd131072 : 18'(sum_s));
    new_c = (sum_c > 21'sd131071) ? 18'sd131071 :
            ((sum_c < -21'sd131072) ? -18'sd131072 : 18'(sum_c));
  end

  // Vectoring set-up
  logic signed [CW-1:0] vx, vy;
  always_comb begin
    vx = CW'(cos_avg_q) <<< 8;
    vy = CW'(sin_avg_q) <<< 8;
  end

  // Angle back to 0.01 degree
  logic signed [37:0] zz;
  logic signed [21:0] cd;
  logic [15:0] cd_w;
  always_comb begin
    zz = 38'(z_q) * 38'sd100 + 38'sd32768;
    cd = 22'(zz >>> 16);
    if (zero_q) cd_w = '0;
    else if (cd < 0) cd_w = 16'(cd + 22'sd36000);
    else if (cd >= 22'sd36000) cd_w = 16'(cd - 22'sd36000);
    else cd_w = 16'(cd);
  end

  // Track error
  logic signed [16:0] err, err_w;
  always_comb begin
    err = signed'({1'b0, bearing_q}) - signed'({1'b0, hold_q});
    if (err > 17'sd18000) err_w = err - 17'sd36000;
    else if (err < -17'sd18000) err_w = err + 17'sd36000;
    else err_w = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q <= ENTER_RST;
      exit_q <= EXIT_RST;
      alpha_q <= ALPHA_RST;
      latch_q <= 1'b0;
      seeded_q <= 1'b0;
      sin_avg_q <= '0;
      cos_avg_q <= '0;
      hold_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENTER: enter_q <= cfg_data_i[13:0];
          CFG_EXIT:  exit_q <= cfg_data_i[13:0];
          CFG_ALPHA: alpha_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) latch_q <= latch_d;
      if (cmd_i.smooth) begin
        seeded_q <= 1'b1;
        sin_avg_q <= seeded_q ? new_s : s16_q;
        cos_avg_q <= seeded_q ? new_c : c16_q;
      end
      if (cmd_i.ang) hold_q <= cd_w;
      if (cmd_i.result) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      course_q <= course_mod;
      bearing_q <= bearing_mod;
    end
    if (cmd_i.conv) prod_q <= 64'({course_q, 16'd0} + 32'd50) * 64'(RECIP_100);
    if (cmd_i.rot_init) begin
      x_q <= GAIN;
      y_q <= '0;
      z_q <= a2;
      flip_q <= flip_d;
      vec_q <= 1'b0;
      i_q <= '0;
    end
    if (cmd_i.vec_init) begin
      zero_q <= (vx == 0) && (vy == 0);
      x_q <= (vx < 0) ? -vx : vx;
      y_q <= (vx < 0) ? -vy : vy;
      z_q <= (vx < 0) ? D180 : '0;
      vec_q <= 1'b1;
      i_q <= '0;
    end
    if (cmd_i.iter) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.sc) begin
      s16_q <= s16;
      c16_q <= c16;
    end
    if (cmd_i.result) begin
      out_course_q <= hold_q;
      out_dvalid_q <= latch_q && seeded_q;
      out_err_q <= (latch_q && seeded_q) ? 16'(err_w) : '0;
    end
  end

  assign stat_o.trusted = latch_q;
  assign stat_o.iter_last = (i_q == IW'(CORDIC_STEPS - 1));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign damped_course_o = out_course_q;
  assign damped_valid_o = out_dvalid_q;
  assign track_error_o = out_err_q;

endmodule

FILE: rtl/course_vector_smoother_unit.sv
`timescale 1ns / 1ps
// A trusted fix runs conversion, rotation set-up, CORDIC rotation, sine/cosine capture,
// smoothing, vectoring set-up, CORDIC vectoring for atan2 and angle conversion, using one
// shared CORDIC step; an untrusted fix goes straight to the result. One fix at a time.
// Reset: asynchronous, active low; clears averages, latch and held course, loads the
// default thresholds and alpha. No clearing pass.
module course_vector_smoother_unit
  import cvs_pkg::*;
#(
  parameter int CORDIC_STEPS = CVS_CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [13:0]        ground_speed_i,
  input  logic [15:0]        raw_course_i,
  input  logic [15:0]        target_bearing_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        damped_course_o,
  output logic               damped_valid_o,
  output logic signed [15:0] track_error_o
);

  cvs_cmd_t  cmd;
  cvs_stat_t stat;

  cvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cvs_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .ground_speed_i   (ground_speed_i),
    .raw_course_i     (raw_course_i),
    .target_bearing_i (target_bearing_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .damped_course_o  (damped_course_o),
    .damped_valid_o   (damped_valid_o),
    .track_error_o    (track_error_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule

FILE: rtl/cvs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cvs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_idx_i,
  input logic [15:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [13:0]        ground_speed_i,
  input logic [15:0]        raw_course_i,
  input logic [15:0]        target_bearing_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        damped_course_o,
  input logic               damped_valid_o,
  input logic signed [15:0] track_error_o
);

  `CVS_ASSERT_HOLD(a_out_hold, out_valid_o && !out_ready_i, damped_course_o, "result beat changed while stalled")
  `CVS_ASSERT(a_err_zero, (out_valid_o && !damped_valid_o) |-> (track_error_o == 16'sd0), "track error set without valid course")
  `CVS_ASSERT(a_course_range, out_valid_o |-> (damped_course_o < 16'd36000), "damped course out of range")
  `CVS_ASSERT(a_err_range, out_valid_o |-> (track_error_o >= -16'sd18000 && track_error_o <= 16'sd18000), "track error out of range")

endmodule

bind course_vector_smoother_unit cvs_checker u_cvs_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cvs_pkg::*;

  typedef struct packed {
    logic [15:0] course;
    logic        valid;
    logic [15:0] err;
  } fix_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = 2'd0;
  logic [15:0] cfg_data_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [13:0] ground_speed_i = 14'd0;
  logic [15:0] raw_course_i = 16'd0;
  logic [15:0] target_bearing_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] damped_course_o;
  logic        damped_valid_o;
  logic signed [15:0] track_error_o;

  course_vector_smoother_unit dut (.*);

  always #6 clk_i = ~clk_i;

  localparam int STEPS = CVS_CORDIC_STEPS;
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  longint enter_thr, exit_thr, alpha;
  longint sin_avg, cos_avg, held_course;
  bit     trusted, seeded;
  fix_result_t pending_fixes[$];
  int     fails = 0;
  bit     calm = 1'b0;

  function automatic longint fdiv_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate_sincos(longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    x = 10188014; y = 0; flip = 0;
    if (ang > 90 * 65536) begin
      ang -= 180 * 65536; flip = 1;
    end else if (ang < -90 * 65536) begin
      ang += 180 * 65536; flip = 1;
    end
    z = ang;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint vector_angle_cd(longint yi, longint xi);
    longint x, y, z, dx, dy, cd;
    x = xi * 256; y = yi * 256; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 180 * 65536;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    cd = ((z * 100 + 32768) >>> 16) % 36000;
    if (cd < 0) cd += 36000;
    return cd;
  endfunction

  function automatic longint blend(longint avg, longint sample);
    return clip(avg + ((alpha * (sample - avg) + 32768) >>> 16), -131072, 131071);
  endfunction

  function automatic fix_result_t predict_fix(logic [13:0] spd, logic [15:0] crs,
                                              logic [15:0] brg);
    fix_result_t r;
    longint c, b, ang, s24, c24, s16, c16, e;
    c = longint'(crs) % 36000;
    b = longint'(brg) % 36000;
    e = 0;
    if (spd >= enter_thr) trusted = 1;
    else if (spd < exit_thr) trusted = 0;
    if (trusted) begin
      ang = (c * 65536 + 50) / 100;
      if (ang > 180 * 65536) ang -= 360 * 65536;
      rotate_sincos(ang, s24, c24);
      s16 = clip((s24 + 128) >>> 8, -65536, 65536);
      c16 = clip((c24 + 128) >>> 8, -65536, 65536);
      if (!seeded) begin
        sin_avg = s16; cos_avg = c16; seeded = 1;
      end else begin
        sin_avg = blend(sin_avg, s16);
        cos_avg = blend(cos_avg, c16);
      end
      held_course = vector_angle_cd(sin_avg, cos_avg);
    end
    if (trusted && seeded) begin
      e = b - held_course;
      if (e > 18000) e -= 36000;
      else if (e < -18000) e += 36000;
    end
    r.course = held_course[15:0];
    r.valid = trusted && seeded;
    r.err = e[15:0];
    return r;
  endfunction

  task automatic send_fix(logic [13:0] spd, logic [15:0] crs, logic [15:0] brg);
    while (!calm && $urandom_range(99) < 9) @(posedge clk_i);
    in_valid_i <= 1'b1;
    ground_speed_i <= spd;
    raw_course_i <= crs;
    target_bearing_i <= brg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_fixes.push_back(predict_fix(spd, crs, brg));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENTER: enter_thr = val[13:0];
      CFG_EXIT:  exit_thr = val[13:0];
      default:   alpha = val;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    fix_result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (pending_fixes.size() == 0) begin
        $display("%t unexpected result course=%0d", $realtime, damped_course_o);
        fails++;
      end else begin
        exp_r = pending_fixes.pop_front();
        if (exp_r.course !== damped_course_o) begin
          $display("%t damped_course exp %0d got %0d", $realtime, exp_r.course,
                   damped_course_o);
          fails++;
        end
        if (exp_r.valid !== damped_valid_o) begin
          $display("%t damped_valid exp %0d got %0d", $realtime, exp_r.valid,
                   damped_valid_o);
          fails++;
        end
        if (exp_r.err !== track_error_o) begin
          $display("%t track_error exp %0d got %0d", $realtime, $signed(exp_r.err),
                   track_error_o);
          fails++;
        end
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 9);
  end

  task automatic test_directed();
    send_fix(14'd0, 16'd0, 16'd0);
    send_fix(14'd100, 16'd0, 16'd35999);
    send_fix(14'd10000, 16'd9000, 16'd0);
    send_fix(14'd90, 16'd18000, 16'd27000);
    send_fix(14'd79, 16'd27000, 16'd100);
    send_fix(14'd200, 16'd35999, 16'd18000);
    send_fix(14'd16383, 16'd65535, 16'd65535);
    send_fix(14'd500, 16'd36000, 16'd36000);
    send_fix(14'd500, 16'd18001, 16'd1);
    send_fix(14'd500, 16'd17999, 16'd35000);
    send_fix(14'd500, 16'd9001, 16'd27001);
    send_fix(14'd0, 16'd100, 16'd200);
    send_fix(14'd120, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_cancel_vector();
    write_reg(CFG_ALPHA, 16'd32768);
    send_fix(14'd300, 16'd0, 16'd0);
    send_fix(14'd300, 16'd18000, 16'd0);
    drain();
    write_reg(CFG_ALPHA, 16'd65535);
    send_fix(14'd300, 16'd18000, 16'd9000);
    send_fix(14'd300, 16'd0, 16'd9000);
    drain();
  endtask

  task automatic test_thresholds(logic [13:0] en, logic [13:0] ex, logic [15:0] a, int n);
    write_reg(CFG_ENTER, 16'(en));
    write_reg(CFG_EXIT, 16'(ex));
    write_reg(CFG_ALPHA, a);
    for (int i = 0; i < n; i++) begin
      logic [13:0] spd;
      if ($urandom_range(9) == 0) spd = 14'($urandom);
      else spd = 14'(clip(longint'(en) + $urandom_range(60) - 30, 0, 10000));
      send_fix(spd, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(35999)),
               ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(35999)));
    end
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 120);
      if (i % 50 == 0) write_reg(CFG_ALPHA, (i % 100 == 0) ? 16'($urandom) : 16'd6554);
      send_fix(($urandom_range(3) == 0) ? 14'($urandom_range(150)) :
               14'($urandom_range(10000)), 16'($urandom), 16'($urandom));
      if (i % 50 == 49) drain();
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    enter_thr = 100; exit_thr = 80; alpha = 6554;
    sin_avg = 0; cos_avg = 0; held_course = 0; trusted = 0; seeded = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_cancel_vector();
    test_thresholds(14'd0, 14'd0, 16'd0, 40);
    test_thresholds(14'd10000, 14'd10000, 16'd65535, 40);
    test_thresholds(14'd16383, 14'd16383, 16'd1, 30);
    test_thresholds(14'd50, 14'd200, 16'd6554, 60);
    test_thresholds(14'd200, 14'd150, 16'd40000, 80);
    test_random(1500);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
